@@ rtl/block_map_allocator_defines.svh @@
// assertion macros of the block map allocator rtl, used by bma_ctrl
`ifndef BLOCK_MAP_ALLOCATOR_DEFINES_SVH
`define BLOCK_MAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BMA_ASSERT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BMA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bma_pkg.sv @@
// types, constants and codes of the block map allocator
package bma_pkg;

  localparam int NUM_BLOCKS_DEF  = 1024;
  localparam int BLOCK_BYTES_DEF = 64;

  localparam int SIZE_W = 17;
  localparam int OFFS_W = 16;
  localparam int CHG_W  = 11;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } bma_mode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ZERO   = 2'd1,
    ST_NOROOM = 2'd2,
    ST_RANGE  = 2'd3
  } bma_status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_MARK,
    S_FREE_RD,
    S_CLR_RUN,
    S_RESULT
  } bma_state_e;

  typedef struct packed {
    bma_mode_e         mode;
    logic [SIZE_W-1:0] size_bytes;
    logic [OFFS_W-1:0] pool_offset;
  } bma_in_t;

  typedef struct packed {
    bma_status_e       status;
    logic [OFFS_W-1:0] block_offset;
    logic [CHG_W-1:0]  blocks_changed;
  } bma_out_t;

  typedef struct packed {
    logic              done;
    logic              rem_nz;
    logic [SIZE_W-1:0] quot;
  } bma_div_rsp_t;

endpackage

@@ rtl/bma_div.sv @@
// block count and remainder flag of a byte count, by shift and mask
module bma_div import bma_pkg::*; #(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SIZE_W-1:0] dividend_i,
  output bma_div_rsp_t      rsp_o
);

  // block size must be a power of two, which this block does not check; the quotient is a plain shift
  localparam int                RW       = $clog2(BLOCK_BYTES);
  localparam logic [SIZE_W-1:0] REM_MASK = SIZE_W'(BLOCK_BYTES - 1);

  logic              done_q;
  logic              rem_nz_q;
  logic [SIZE_W-1:0] quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q   <= dividend_i >> RW;
      rem_nz_q <= |(dividend_i & REM_MASK);
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.rem_nz = rem_nz_q;
  assign rsp_o.quot   = quot_q;

endmodule

@@ rtl/bma_map_ram.sv @@
// owner length map, one write and one registered read port
module bma_map_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 11
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

@@ rtl/bma_ctrl.sv @@
// sequencer: clearing pass, first-fit scan, run marking and freeing
`include "block_map_allocator_defines.svh"
module bma_ctrl import bma_pkg::*; #(
  parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int IDX_W       = $clog2(NUM_BLOCKS),
  parameter int CNT_W       = $clog2(NUM_BLOCKS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bma_in_t           in_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output bma_out_t          res_o,
  output logic              div_start_o,
  output logic [SIZE_W-1:0] div_dividend_o,
  input  bma_div_rsp_t      div_rsp_i,
  output logic              wr_en_o,
  output logic [IDX_W-1:0]  wr_addr_o,
  output logic [CNT_W-1:0]  wr_data_o,
  output logic              rd_en_o,
  output logic [IDX_W-1:0]  rd_addr_o,
  input  logic [CNT_W-1:0]  rd_data_i
);

  localparam logic [31:0]      POOL_BYTES = 32'(NUM_BLOCKS) * 32'(BLOCK_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(NUM_BLOCKS - 1);

  bma_state_e       state_q, state_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic [IDX_W-1:0] base_q, base_d;
  logic [CNT_W-1:0] need_q, need_d;
  logic [CNT_W-1:0] run_q, run_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  bma_mode_e        mode_q, mode_d;
  bma_out_t         res_q, res_d;

  logic [31:0]      need32, room32, off32, chg32;
  logic [CNT_W-1:0] run_n, room, len_c;

  assign need32 = 32'(div_rsp_i.quot) + 32'(div_rsp_i.rem_nz);
  assign run_n  = (rd_data_i == '0) ? run_q + CNT_W'(1) : '0;
  assign room32 = 32'(NUM_BLOCKS) - 32'(ptr_q);
  assign room   = room32[CNT_W-1:0];
  // a free never clears past the last block
  assign len_c  = (rd_data_i > room) ? room : rd_data_i;
  assign off32  = 32'(base_q) * 32'(BLOCK_BYTES);
  assign chg32  = 32'(need_q);

  always_comb begin
    state_d        = state_q;
    ptr_d          = ptr_q;
    base_d         = base_q;
    need_d         = need_q;
    run_d          = run_q;
    cnt_d          = cnt_q;
    mode_d         = mode_q;
    res_d          = res_q;
    in_stall_o     = 1'b1;
    div_start_o    = 1'b0;
    div_dividend_o = (in_i.mode == MODE_FREE) ? {1'b0, in_i.pool_offset}
                                              : in_i.size_bytes;
    wr_en_o        = 1'b0;
    wr_addr_o      = ptr_q;
    wr_data_o      = '0;
    rd_en_o        = 1'b0;
    rd_addr_o      = ptr_q;

    unique case (state_q)
      S_CLEAR: begin
        wr_en_o = 1'b1;
        if (ptr_q == LAST_IDX) begin
          ptr_d   = '0;
          state_d = S_IDLE;
        end else begin
          ptr_d = ptr_q + IDX_W'(1);
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          mode_d               = in_i.mode;
          res_d.block_offset   = '0;
          res_d.blocks_changed = '0;
          if (in_i.mode == MODE_ALLOC && in_i.size_bytes == '0) begin
            res_d.status = ST_ZERO;
            state_d      = S_RESULT;
          end else if (in_i.mode == MODE_FREE &&
                       32'(in_i.pool_offset) >= POOL_BYTES) begin
            res_d.status = ST_RANGE;
            state_d      = S_RESULT;
          end else begin
            div_start_o = 1'b1;
            state_d     = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_rsp_i.done) begin
          if (mode_q == MODE_ALLOC) begin
            if (need32 > 32'(NUM_BLOCKS)) begin
              res_d.status = ST_NOROOM;
              state_d      = S_RESULT;
            end else begin
              need_d    = need32[CNT_W-1:0];
              run_d     = '0;
              ptr_d     = LAST_IDX;
              rd_en_o   = 1'b1;
              rd_addr_o = LAST_IDX;
              state_d   = S_SCAN;
            end
          end else begin
            ptr_d     = div_rsp_i.quot[IDX_W-1:0];
            rd_en_o   = 1'b1;
            rd_addr_o = div_rsp_i.quot[IDX_W-1:0];
            state_d   = S_FREE_RD;
          end
        end
      end
      S_SCAN: begin
        // rd_data_i is the entry at ptr_q; the next lower one is fetched meanwhile
        if (run_n >= need_q) begin
          base_d  = ptr_q;
          cnt_d   = need_q;
          state_d = S_MARK;
        end else if (ptr_q == '0) begin
          res_d.status = ST_NOROOM;
          state_d      = S_RESULT;
        end else begin
          run_d     = run_n;
          ptr_d     = ptr_q - IDX_W'(1);
          rd_en_o   = 1'b1;
          rd_addr_o = ptr_q - IDX_W'(1);
        end
      end
      S_MARK: begin
        wr_en_o   = 1'b1;
        wr_data_o = need_q;
        ptr_d     = ptr_q + IDX_W'(1);
        cnt_d     = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          res_d.status         = ST_OK;
          res_d.block_offset   = off32[OFFS_W-1:0];
          res_d.blocks_changed = chg32[CHG_W-1:0];
          state_d              = S_RESULT;
        end
      end
      S_FREE_RD: begin
        need_d = len_c;
        cnt_d  = len_c;
        if (len_c == '0) begin
          res_d.status = ST_OK;
          state_d      = S_RESULT;
        end else begin
          state_d = S_CLR_RUN;
        end
      end
      S_CLR_RUN: begin
        wr_en_o = 1'b1;
        ptr_d   = ptr_q + IDX_W'(1);
        cnt_d   = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          res_d.status         = ST_OK;
          res_d.blocks_changed = chg32[CHG_W-1:0];
          state_d              = S_RESULT;
        end
      end
      S_RESULT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_valid_o = (state_q == S_RESULT);
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    need_q <= need_d;
    run_q  <= run_d;
    cnt_q  <= cnt_d;
    mode_q <= mode_d;
    res_q  <= res_d;
  end

  `BMA_ASSERT(a_idle_no_write, clk_i, rst_ni, state_q == S_IDLE, !wr_en_o,
              "map written while idle")
  `BMA_ASSERT(a_run_cnt_nz, clk_i, rst_ni, state_q == S_MARK || state_q == S_CLR_RUN,
              cnt_q != '0, "run count zero during write")
  `BMA_ASSERT(a_mark_len_nz, clk_i, rst_ni, state_q == S_MARK,
              need_q != '0 && cnt_q <= need_q, "bad mark length")
  `BMA_ASSERT_NEXT(a_res_to_idle, clk_i, rst_ni, res_valid_o && res_ready_i,
                   state_q == S_IDLE, "result taken but not idle")

endmodule

@@ rtl/block_map_allocator.sv @@
// channel  | handshake              | payload
// request  | in_valid_i / in_stall_o   | in_i  (mode, size_bytes, pool_offset)
// result   | out_valid_o / out_stall_i | out_o (status, block_offset, blocks_changed)
//
// zero size or out of range offset: a result with no divide and no map access
// allocate: divide, then a scan down from the last block with one map read per scan
//   step and one write per marked block; no scan if too long, a full scan if no run fits
// free: divide, read of the owner length, then one map write per cleared block
// after reset a clearing pass zeroes every map entry before the first request is taken
// one request is in work at a time; a result may wait in the output register while
//   the next request is taken, and an output stall holds a new result in S_RESULT
module block_map_allocator import bma_pkg::*; #(
  parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  bma_in_t  in_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output bma_out_t out_o
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  logic              div_start;
  logic [SIZE_W-1:0] div_dividend;
  bma_div_rsp_t      div_rsp;
  logic              wr_en, rd_en;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  logic [CNT_W-1:0]  wr_data, rd_data;
  logic              res_valid, res_ready, load;
  bma_out_t          res;
  logic              out_valid_q;
  bma_out_t          out_q;

  bma_div #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .rsp_o      (div_rsp)
  );

  bma_map_ram #(
    .DEPTH(NUM_BLOCKS),
    .AW   (IDX_W),
    .DW   (CNT_W)
  ) u_map (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  bma_ctrl #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .BLOCK_BYTES(BLOCK_BYTES),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_i           (in_i),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .div_start_o    (div_start),
    .div_dividend_o (div_dividend),
    .div_rsp_i      (div_rsp),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data)
  );

  // output slot takes a new result when empty or being drained this cycle
  assign res_ready = !out_valid_q || !out_stall_i;
  assign load      = res_valid && res_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
